>>> hdl/escape_sequence_decoder_unit_defines.svh
// Assertion macros shared by the escape decoder files.
`ifndef ESCAPE_SEQUENCE_DECODER_UNIT_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define ESDU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("escape decoder check failed");

// Next-cycle implication, disabled while in reset.
`define ESDU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("escape decoder check failed");

`else

`define ESDU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ESDU_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/esd_pkg.sv
// Types and constants shared by the escape decoder modules.
package esd_pkg;

    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_ESC   = 3'd1;
    localparam logic [2:0] MODE_HEX   = 3'd2;
    localparam logic [2:0] MODE_OCT   = 3'd3;
    localparam logic [2:0] MODE_ZERO  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ESC   = 2'd1;
    localparam logic [1:0] ST_BAD_DIGIT = 2'd2;
    localparam logic [1:0] ST_UNFINISH  = 2'd3;

    // Result queue geometry.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;
    localparam int RQ_CW    = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       out_last;
    } t_result;

    // Results produced by one item: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0]       count;
        t_result [1:0]    res;
    } t_dec_out;

endpackage

>>> hdl/esd_if.sv
// Handshake channel interfaces for the escape decoder input and output.
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       out_last;

    modport source (output valid, output out_byte, output status, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input out_last,
                    output ready);
endinterface

>>> hdl/escape_sequence_decoder_unit.sv
// Escape sequence decoder top level: input register, decode, result queue.
//
// Decodes a stream of C-style escaped characters at one byte per cycle. Each
// input transfer lands in an input register; once the queue has room for
// its results, the decode logic updates the escape state and writes zero,
// one or two results into a four-entry result queue that drives the output
// channel. A new byte is taken every cycle as long as the queue has room for
// that byte's results; the only byte that can yield two results (a non-octal
// byte after \0) needs more than one output transfer, so the sustained rate
// is one byte per cycle while the output keeps up and the output side is the
// limit otherwise.
`include "escape_sequence_decoder_unit_defines.svh"

module escape_sequence_decoder_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    esd_in_if.sink    i_in,
    esd_out_if.source o_out
);
    import esd_pkg::*;

    logic               r_vld;
    logic [7:0]         r_byte;
    logic               r_last;
    logic               fire;
    t_dec_out           dec;
    logic [RQ_CW-1:0]   free;
    logic               pop;
    logic               q_valid;
    t_result            q_head;

    assign pop  = q_valid && o_out.ready;
    assign fire = r_vld && (free >= RQ_CW'(dec.count));
    assign i_in.ready = !r_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_vld <= 1'b1;
        end else if (fire) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.in_byte;
            r_last <= i_in.in_last;
        end
    end

    esd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_byte),
        .i_last  (r_last),
        .o_dec   (dec)
    );

    esd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (fire ? dec.count : 2'd0),
        .i_res    (dec.res),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_head   (q_head),
        .o_free   (free)
    );

    assign o_out.valid    = q_valid;
    assign o_out.out_byte = q_head.out_byte;
    assign o_out.status   = q_head.status;
    assign o_out.out_last = q_head.out_last;

    `ESDU_ASSERT_NXT(a_hold_unfired, i_clk, i_rst_n, r_vld && !fire,
        r_vld && $stable(r_byte) && $stable(r_last))
    `ESDU_ASSERT_IMP(a_room_check, i_clk, i_rst_n, fire,
        free >= RQ_CW'(dec.count))
    `ESDU_ASSERT_IMP(a_err_byte_zero, i_clk, i_rst_n, o_out.valid && o_out.status != ST_OK,
        o_out.out_byte == 8'd0)

endmodule

>>> hdl/esd_decode.sv
// Escape decoder state and per-byte decode logic.
`include "escape_sequence_decoder_unit_defines.svh"

module esd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output esd_pkg::t_dec_out o_dec
);
    import esd_pkg::*;

    logic [2:0]     r_mode;
    logic [8:0]     r_val;
    logic [1:0]     r_left;
    logic [2:0]     n_mode;
    logic [8:0]     n_val;
    logic [1:0]     n_left;

    logic           hex_ok;
    logic [3:0]     hex_d;
    logic           oct_ok;
    logic           esc_ok;
    logic [7:0]     esc_code;
    logic           done;
    logic [1:0]     cnt;
    t_result [1:0]  res;

    always_comb begin
        hex_ok = 1'b1;
        hex_d  = i_byte[3:0];
        if (i_byte inside {[8'h30:8'h39]}) begin
            hex_d = i_byte[3:0];
        end else if (i_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            hex_d = i_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
        oct_ok = i_byte inside {[8'h30:8'h37]};
    end

    always_comb begin
        esc_ok   = 1'b1;
        esc_code = i_byte;
        case (i_byte)
            8'h61:   esc_code = 8'd7;
            8'h62:   esc_code = 8'd8;
            8'h66:   esc_code = 8'd12;
            8'h6E:   esc_code = 8'd10;
            8'h72:   esc_code = 8'd13;
            8'h74:   esc_code = 8'd9;
            8'h76:   esc_code = 8'd11;
            8'h5C, 8'h3F, 8'h27, 8'h22: esc_code = i_byte;
            default: esc_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_mode = r_mode;
        n_val  = r_val;
        n_left = r_left;
        cnt    = '0;
        res    = '0;
        done   = 1'b0;
        if (n_mode > MODE_ZERO) begin
            n_mode = MODE_PLAIN;
            n_val  = '0;
            n_left = '0;
        end
        // After \0: a second octal digit continues, anything else flushes a NUL
        if (n_mode == MODE_ZERO) begin
            if (oct_ok) begin
                n_mode = MODE_OCT;
                n_val  = {6'd0, i_byte[2:0]};
                n_left = 2'd1;
                done   = 1'b1;
                if (i_last) begin
                    res[0] = '{8'd0, ST_UNFINISH, 1'b1};
                    cnt    = 2'd1;
                    n_mode = MODE_PLAIN;
                    n_val  = '0;
                    n_left = '0;
                end
            end else begin
                res[0] = '{8'd0, ST_OK, 1'b0};
                cnt    = 2'd1;
                n_mode = MODE_PLAIN;
                n_val  = '0;
                n_left = '0;
            end
        end
        if (!done) begin
            case (n_mode)
                MODE_PLAIN: begin
                    if (i_byte == 8'h5C) begin
                        n_mode = MODE_ESC;
                    end else begin
                        res[cnt[0]] = '{i_byte, ST_OK, i_last};
                        cnt         = cnt + 2'd1;
                    end
                end
                MODE_ESC: begin
                    if (esc_ok) begin
                        res[cnt[0]] = '{esc_code, ST_OK, i_last};
                        cnt         = cnt + 2'd1;
                        n_mode      = MODE_PLAIN;
                        n_val       = '0;
                        n_left      = '0;
                    end else if (i_byte == 8'h78) begin
                        n_mode = MODE_HEX;
                        n_val  = '0;
                        n_left = 2'd2;
                    end else if (i_byte == 8'h30) begin
                        n_mode = MODE_ZERO;
                        n_val  = '0;
                        n_left = '0;
                    end else if (oct_ok) begin
                        n_mode = MODE_OCT;
                        n_val  = {6'd0, i_byte[2:0]};
                        n_left = 2'd2;
                    end else begin
                        res[cnt[0]] = '{8'd0, ST_BAD_ESC, i_last};
                        cnt         = cnt + 2'd1;
                        n_mode      = MODE_PLAIN;
                        n_val       = '0;
                        n_left      = '0;
                    end
                end
                MODE_HEX, MODE_OCT: begin
                    if ((n_mode == MODE_HEX) ? !hex_ok : !oct_ok) begin
                        res[cnt[0]] = '{8'd0, ST_BAD_DIGIT, i_last};
                        cnt         = cnt + 2'd1;
                        n_mode      = MODE_PLAIN;
                        n_val       = '0;
                        n_left      = '0;
                    end else begin
                        // Shift in one digit, keep nine bits
                        if (n_mode == MODE_HEX) begin
                            n_val = {n_val[4:0], hex_d};
                        end else begin
                            n_val = {n_val[5:0], i_byte[2:0]};
                        end
                        n_left = n_left - 2'd1;
                        if (n_left == 2'd0) begin
                            res[cnt[0]] = '{n_val[7:0], ST_OK, i_last};
                            cnt         = cnt + 2'd1;
                            n_mode      = MODE_PLAIN;
                            n_val       = '0;
                            n_left      = '0;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_PLAIN;
                    n_val  = '0;
                    n_left = '0;
                end
            endcase
            if (n_mode != MODE_PLAIN && i_last) begin
                res[cnt[0]] = '{8'd0, ST_UNFINISH, 1'b1};
                cnt         = cnt + 2'd1;
                n_mode      = MODE_PLAIN;
                n_val       = '0;
                n_left      = '0;
            end
        end
    end

    assign o_dec.count = cnt;
    assign o_dec.res   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_val  <= '0;
            r_left <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_val  <= n_val;
            r_left <= n_left;
        end
    end

    `ESDU_ASSERT_NXT(a_last_to_plain, i_clk, i_rst_n, i_fire && i_last,
        r_mode == MODE_PLAIN && r_val == 9'd0 && r_left == 2'd0)
    `ESDU_ASSERT_IMP(a_two_lead_nul, i_clk, i_rst_n, i_fire && cnt == 2'd2,
        res[0].status == ST_OK && !res[0].out_last && res[0].out_byte == 8'd0)
    `ESDU_ASSERT_IMP(a_err_zero, i_clk, i_rst_n,
        i_fire && cnt != 2'd0 && res[0].status != ST_OK, res[0].out_byte == 8'd0)

endmodule

>>> hdl/esd_fifo.sv
// Result queue: takes up to two results per cycle, delivers one.
module esd_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_push_n,
    input  esd_pkg::t_result [1:0]      i_res,
    input  logic                        i_pop,
    output logic                        o_valid,
    output esd_pkg::t_result            o_head,
    output logic [esd_pkg::RQ_CW-1:0]   o_free
);
    import esd_pkg::*;

    t_result            r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0]   r_wp;
    logic [RQ_AW-1:0]   r_rp;
    logic [RQ_CW-1:0]   r_cnt;

    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp];
    // Room left once this cycle's transfer has gone out
    assign o_free  = RQ_CW'(RQ_DEPTH) - r_cnt + RQ_CW'(i_pop);

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_res[0];
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wp + RQ_AW'(1)] <= i_res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + RQ_AW'(i_push_n);
            r_rp  <= r_rp + RQ_AW'(i_pop);
            r_cnt <= r_cnt + RQ_CW'(i_push_n) - RQ_CW'(i_pop);
        end
    end

endmodule

>>> bench/escape_sequence_decoder_unit_tb.sv
// Self-checking bench for the escape sequence decoder: random escaped strings, random flow control.
module escape_sequence_decoder_unit_tb;

    import esd_pkg::*;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X    = "x";
    localparam logic [7:0] CHAR_ZERO = "0";
    localparam logic [7:0] CHAR_ONE  = "1";
    localparam logic [7:0] CHAR_SEVEN = "7";

    typedef struct {
        logic [7:0] ch;
        logic       lst;
        bit         drain_first;
    } t_char_item;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_style;

    logic i_clk;
    logic i_rst_n;

    esd_in_if  in_ch ();
    esd_out_if out_ch ();

    escape_sequence_decoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_char_item pending_chars [$];
    logic [7:0] build_q [$];
    t_result    expected_results [$];

    // Decoder state as the bench sees it
    logic [2:0] esc_mode   = MODE_PLAIN;
    logic [8:0] acc_value  = '0;
    logic [1:0] digits_due = '0;

    int mismatches      = 0;
    int chars_queued    = 0;
    int chars_sent      = 0;
    int strings_built   = 0;
    int results_checked = 0;
    int status_seen [4] = '{default: 0};
    int burst_left      = 1;
    int gap_left        = 0;
    int style_left      = 0;
    int cycle_count     = 0;
    t_rx_style rx_style = RX_OPEN;
    t_result   want;

    string esc_letters = "abfnrtv\\?'\"";
    string hex_digits  = "0123456789abcdefABCDEF";

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    // ---------------- prediction ----------------

    function void expect_result(input logic [7:0] ch, input logic [1:0] st, input logic lst);
        t_result r;
        r.out_byte = ch;
        r.status   = st;
        r.out_last = lst;
        expected_results.push_back(r);
    endfunction

    function void clear_escape();
        esc_mode   = MODE_PLAIN;
        acc_value  = '0;
        digits_due = '0;
    endfunction

    function int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function int octal_value(input logic [7:0] c);
        if (c >= "0" && c <= "7") return int'(c - "0");
        return -1;
    endfunction

    function int escape_code(input logic [7:0] c);
        case (c)
            "a": return 7;
            "b": return 8;
            "f": return 12;
            "n": return 10;
            "r": return 13;
            "t": return 9;
            "v": return 11;
            "\\", "?", "'", "\"": return int'(c);
            default: return -1;
        endcase
    endfunction

    function void decode_char(input logic [7:0] c, input logic lst);
        int v;
        if (esc_mode > MODE_ZERO) clear_escape();
        if (esc_mode == MODE_ZERO) begin
            v = octal_value(c);
            if (v >= 0) begin
                acc_value  = 9'(v);
                digits_due = 2'd1;
                esc_mode   = MODE_OCT;
                if (lst) begin
                    expect_result(8'h00, ST_UNFINISH, 1'b1);
                    clear_escape();
                end
                return;
            end
            // NUL goes out first, then the byte is taken in plain mode
            expect_result(8'h00, ST_OK, 1'b0);
            clear_escape();
        end
        case (esc_mode)
            MODE_PLAIN: begin
                if (c == BACKSLASH) esc_mode = MODE_ESC;
                else expect_result(c, ST_OK, lst);
            end
            MODE_ESC: begin
                v = escape_code(c);
                if (v >= 0) begin
                    expect_result(v[7:0], ST_OK, lst);
                    clear_escape();
                end else if (c == CHAR_X) begin
                    esc_mode   = MODE_HEX;
                    acc_value  = '0;
                    digits_due = 2'd2;
                end else if (c == CHAR_ZERO) begin
                    esc_mode   = MODE_ZERO;
                    acc_value  = '0;
                    digits_due = '0;
                end else if (c >= CHAR_ONE && c <= CHAR_SEVEN) begin
                    esc_mode   = MODE_OCT;
                    acc_value  = 9'(c - CHAR_ZERO);
                    digits_due = 2'd2;
                end else begin
                    expect_result(8'h00, ST_BAD_ESC, lst);
                    clear_escape();
                end
            end
            MODE_HEX, MODE_OCT: begin
                v = (esc_mode == MODE_HEX) ? hex_value(c) : octal_value(c);
                if (v < 0) begin
                    expect_result(8'h00, ST_BAD_DIGIT, lst);
                    clear_escape();
                end else begin
                    if (esc_mode == MODE_HEX) acc_value = 9'(acc_value * 16 + v);
                    else acc_value = 9'(acc_value * 8 + v);
                    digits_due = digits_due - 2'd1;
                    if (digits_due == 0) begin
                        expect_result(acc_value[7:0], ST_OK, lst);
                        clear_escape();
                    end
                end
            end
            default: clear_escape();
        endcase
        if (esc_mode != MODE_PLAIN && lst) begin
            expect_result(8'h00, ST_UNFINISH, 1'b1);
            clear_escape();
        end
    endfunction

    // ---------------- stimulus building ----------------

    function logic [7:0] rand_hex();
        return hex_digits[$urandom_range(0, 21)];
    endfunction

    function logic [7:0] rand_octal();
        return CHAR_ZERO + 8'($urandom_range(0, 7));
    endfunction

    function void add_text(input string s);
        for (int i = 0; i < s.len(); i++) build_q.push_back(s[i]);
    endfunction

    // Move the built string to the send queue; optionally cut it short, maybe mid-escape.
    function void flush_string(input bit drain, input bit cut);
        t_char_item it;
        int n;
        if (cut && build_q.size() > 1) begin
            n = $urandom_range(1, build_q.size() - 1);
            while (build_q.size() > n) void'(build_q.pop_back());
        end
        for (int i = 0; i < build_q.size(); i++) begin
            it.ch          = build_q[i];
            it.lst         = (i == build_q.size() - 1);
            it.drain_first = drain && (i == 0);
            pending_chars.push_back(it);
        end
        chars_queued += build_q.size();
        strings_built++;
        build_q.delete();
    endfunction

    function void add_token();
        logic [7:0] c;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: build_q.push_back(8'($urandom_range(0, 255)));
            6, 7, 8: begin
                build_q.push_back(BACKSLASH);
                build_q.push_back(esc_letters[$urandom_range(0, 10)]);
            end
            9, 10: begin
                build_q.push_back(BACKSLASH);
                build_q.push_back(CHAR_X);
                build_q.push_back(rand_hex());
                build_q.push_back(rand_hex());
            end
            11, 12: begin
                build_q.push_back(BACKSLASH);
                build_q.push_back(CHAR_ONE + 8'($urandom_range(0, 6)));
                build_q.push_back(rand_octal());
                build_q.push_back(rand_octal());
            end
            13, 14: begin
                build_q.push_back(BACKSLASH);
                build_q.push_back(CHAR_ZERO);
                build_q.push_back(rand_octal());
                build_q.push_back(rand_octal());
            end
            15: begin
                // short \0: next byte is never an octal digit
                c = 8'($urandom_range(0, 255));
                build_q.push_back(BACKSLASH);
                build_q.push_back(CHAR_ZERO);
                build_q.push_back(octal_value(c) >= 0 ? BACKSLASH : c);
            end
            16: begin
                build_q.push_back(BACKSLASH);
                build_q.push_back(8'($urandom_range(0, 255)));
            end
            17: begin
                build_q.push_back(BACKSLASH);
                build_q.push_back(CHAR_X);
                if ($urandom_range(0, 1)) build_q.push_back(rand_hex());
                build_q.push_back(8'($urandom_range(0, 255)));
            end
            18: begin
                build_q.push_back(BACKSLASH);
                build_q.push_back(rand_octal());
                if ($urandom_range(0, 1)) build_q.push_back(rand_octal());
                build_q.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                c = 8'($urandom_range(32, 126));
                build_q.push_back(c == BACKSLASH ? CHAR_X : c);
            end
        endcase
    endfunction

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        i_rst_n       = 1'b0;

        // directed: byte extremes, each escape form, every error kind
        build_q.push_back(8'h00);
        build_q.push_back(8'hFF);
        flush_string(1'b0, 1'b0);
        add_text("\\n\\xFf\\777\\0A\\q");
        flush_string(1'b0, 1'b0);
        add_text("\\xg");
        flush_string(1'b0, 1'b0);
        add_text("\\1");
        flush_string(1'b0, 1'b0);
        add_text("\\0");
        flush_string(1'b0, 1'b0);
        add_text("\\04");
        flush_string(1'b0, 1'b0);
        add_text("\\0\\");
        flush_string(1'b0, 1'b0);

        // random: mostly well-formed strings, some cut short
        while (chars_queued < 830) begin
            repeat ($urandom_range(1, 8)) add_token();
            flush_string(strings_built == 7 || $urandom_range(0, 39) == 0,
                         $urandom_range(0, 7) == 0);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("summary: %0d characters in %0d strings sent, %0d results checked",
                 chars_sent, strings_built, results_checked);
        $display("summary: ok %0d, bad escape %0d, bad digit %0d, unfinished %0d",
                 status_seen[ST_OK], status_seen[ST_BAD_ESC],
                 status_seen[ST_BAD_DIGIT], status_seen[ST_UNFINISH]);
        if (mismatches > 10) $display("%0d mismatches in total", mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                decode_char(pending_chars[0].ch, pending_chars[0].lst);
                void'(pending_chars.pop_front());
                chars_sent++;
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold the offered byte until the transfer happens
            end else if (gap_left != 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_chars.size() != 0 &&
                         !(pending_chars[0].drain_first && expected_results.size() != 0)) begin
                in_ch.valid   <= 1'b1;
                in_ch.in_byte <= pending_chars[0].ch;
                in_ch.in_last <= pending_chars[0].lst;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(0, 4);
                end else begin
                    burst_left--;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor and receiver ----------------

    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_checked++;
            status_seen[out_ch.status]++;
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result: byte %02h status %0d last %0b",
                                        out_ch.out_byte, out_ch.status, out_ch.out_last));
            end else begin
                want = expected_results.pop_front();
                if (out_ch.out_byte !== want.out_byte || out_ch.status !== want.status ||
                    out_ch.out_last !== want.out_last)
                    flag_mismatch($sformatf(
                        "expected byte %02h status %0d last %0b, got byte %02h status %0d last %0b",
                        want.out_byte, want.status, want.out_last,
                        out_ch.out_byte, out_ch.status, out_ch.out_last));
            end
        end

        if (style_left == 0) begin
            rx_style   = t_rx_style'($urandom_range(0, 3));
            style_left = $urandom_range(40, 300);
        end else begin
            style_left--;
        end
        case (rx_style)
            RX_OPEN:   out_ch.ready <= 1'b1;
            RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default:   out_ch.ready <= (cycle_count % 7) < 3;
        endcase
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/esd_pkg.sv
hdl/esd_if.sv
hdl/esd_decode.sv
hdl/esd_fifo.sv
hdl/escape_sequence_decoder_unit.sv
bench/escape_sequence_decoder_unit_tb.sv
